// File: src/assert_macros.svh
// Assertion macros used by the checker module of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is low.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked at every edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// File: src/ucts_pkg.sv
// Types and constants for the USB control transfer sequencer.
// No dependencies.
`default_nettype none

package ucts_pkg;

   localparam int LEN_W = 16;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_OUTCOME = 1'b1;

   typedef enum logic [2:0] {
      STAGE_IDLE       = 3'd0,
      STAGE_SETUP      = 3'd1,
      STAGE_DATA_IN    = 3'd2,
      STAGE_DATA_OUT   = 3'd3,
      STAGE_STATUS_OUT = 3'd4,
      STAGE_STATUS_IN  = 3'd5
   } stage_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_SETUP      = 3'd1,
      ACT_DATA_IN    = 3'd2,
      ACT_DATA_OUT   = 3'd3,
      ACT_STATUS_OUT = 3'd4,
      ACT_STATUS_IN  = 3'd5,
      ACT_FINISHED   = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      URB_DONE  = 2'd0,
      URB_NAK   = 2'd1,
      URB_STALL = 2'd2,
      URB_ERROR = 2'd3
   } urb_type;

   typedef struct packed {
      logic             mode;
      logic             dir_in;
      logic [LEN_W-1:0] data_length;
      logic             device_present;
      logic             pipe_idle;
      urb_type          urb_state;
   } item_type;

   typedef struct packed {
      stage_type        stage;
      logic             retry_used;
      logic             direction_in;
      logic [LEN_W-1:0] stored_length;
   } ctx_type;

   typedef struct packed {
      action_type       action;
      logic             success;
      logic [LEN_W-1:0] transfer_length;
   } result_type;

   // Action reported when a stage is issued.
   function automatic action_type stage_action(input stage_type st);
      action_type a;
      case (st)
         STAGE_SETUP:      a = ACT_SETUP;
         STAGE_DATA_IN:    a = ACT_DATA_IN;
         STAGE_DATA_OUT:   a = ACT_DATA_OUT;
         STAGE_STATUS_OUT: a = ACT_STATUS_OUT;
         STAGE_STATUS_IN:  a = ACT_STATUS_IN;
         default:          a = ACT_NONE;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// File: src/ucts_step.sv
// Stage transition logic: one transaction against the current transfer context.
// Depends on ucts_pkg.
`default_nettype none

module ucts_step
   import ucts_pkg::*;
(
   input  wire ctx_type    cur,
   input  wire item_type   item,
   output ctx_type    nxt,
   output result_type res
);

   always_comb begin
      stage_type  issue_stage;
      logic       do_issue;
      logic       do_err;
      logic       do_fail;
      logic       do_pass;
      action_type act;

      nxt         = cur;
      issue_stage = STAGE_IDLE;
      do_issue    = 1'b0;
      do_err      = 1'b0;
      do_fail     = 1'b0;
      do_pass     = 1'b0;
      act         = ACT_NONE;

      if (item.mode == MODE_START) begin
         // a start while busy is dropped
         if (cur.stage == STAGE_IDLE) begin
            nxt.direction_in  = item.dir_in;
            nxt.stored_length = item.data_length;
            nxt.retry_used    = 1'b0;
            if (!item.device_present || !item.pipe_idle) begin
               do_fail = 1'b1;
            end else begin
               do_issue    = 1'b1;
               issue_stage = STAGE_SETUP;
            end
         end
      end else begin
         case (cur.stage)
            STAGE_SETUP: begin
               case (item.urb_state)
                  URB_DONE: begin
                     do_issue = 1'b1;
                     if (cur.stored_length != '0) begin
                        issue_stage = cur.direction_in ? STAGE_DATA_IN : STAGE_DATA_OUT;
                     end else begin
                        issue_stage = cur.direction_in ? STAGE_STATUS_OUT : STAGE_STATUS_IN;
                     end
                  end
                  URB_NAK, URB_ERROR: do_err = 1'b1;
                  default: ;
               endcase
            end
            STAGE_DATA_IN: begin
               case (item.urb_state)
                  URB_DONE: begin
                     do_issue    = 1'b1;
                     issue_stage = STAGE_STATUS_OUT;
                  end
                  URB_STALL: do_fail = 1'b1;
                  URB_ERROR: do_err  = 1'b1;
                  default: ;
               endcase
            end
            STAGE_DATA_OUT: begin
               case (item.urb_state)
                  URB_DONE: begin
                     do_issue    = 1'b1;
                     issue_stage = STAGE_STATUS_IN;
                  end
                  URB_NAK: begin
                     do_issue    = 1'b1;
                     issue_stage = STAGE_DATA_OUT;
                  end
                  URB_STALL: do_fail = 1'b1;
                  default:   do_err  = 1'b1;
               endcase
            end
            STAGE_STATUS_OUT: begin
               case (item.urb_state)
                  URB_DONE: do_pass = 1'b1;
                  URB_NAK: begin
                     do_issue    = 1'b1;
                     issue_stage = STAGE_STATUS_OUT;
                  end
                  URB_ERROR: do_err = 1'b1;
                  default: ;
               endcase
            end
            STAGE_STATUS_IN: begin
               case (item.urb_state)
                  URB_DONE:  do_pass = 1'b1;
                  URB_STALL: do_fail = 1'b1;
                  URB_ERROR: do_err  = 1'b1;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      // one restart from SETUP per transfer, then give up
      if (do_err) begin
         if (cur.retry_used) begin
            do_fail = 1'b1;
         end else begin
            nxt.retry_used = 1'b1;
            do_issue       = 1'b1;
            issue_stage    = STAGE_SETUP;
         end
      end

      if (do_issue) begin
         nxt.stage = issue_stage;
         act       = stage_action(issue_stage);
      end

      if (do_fail || do_pass) begin
         nxt.stage      = STAGE_IDLE;
         nxt.retry_used = 1'b0;
         act            = ACT_FINISHED;
      end

      res.action          = act;
      res.success         = do_pass;
      res.transfer_length = (act == ACT_DATA_IN || act == ACT_DATA_OUT) ?
                            nxt.stored_length : '0;
   end

endmodule

`default_nettype wire

// File: src/usb_control_transfer_sequencer.sv
// USB host control transfer sequencer, top level; depends on ucts_pkg and ucts_step.
// Response path: a request passes the input register, then the result register, before
// rsp_valid rises. Throughput: one transaction per cycle while rsp_stall is low;
// a stalled response still lets one request in.
// Reset: synchronous, active high; returns to idle with retry, direction and length
// cleared, both pipeline registers empty.
`default_nettype none

module usb_control_transfer_sequencer
   import ucts_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   // request channel
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire logic             req_mode,
   input  wire logic             req_dir_in,
   input  wire logic [LEN_W-1:0] req_data_length,
   input  wire logic             req_device_present,
   input  wire logic             req_pipe_idle,
   input  wire logic [1:0]       req_urb_state,

   // response channel
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      logic [2:0]       rsp_action,
   output      logic             rsp_success,
   output      logic [LEN_W-1:0] rsp_transfer_length
);

   // Two registers part the channels: the input register holds one accepted
   // transaction, the result register holds one response. While a response
   // waits under rsp_stall, one more request is still taken into the input
   // register; only then does req_stall rise.

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff, res_in;
   ctx_type    ctx_ff, ctx_in;

   ctx_type    step_ctx;
   result_type step_res;

   logic req_take;
   logic out_free;
   logic step_fire;

   // the result register can take a new value when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // stage decision against the held transfer context
   ucts_step u_step (
      .cur  (ctx_ff),
      .item (item_ff),
      .nxt  (step_ctx),
      .res  (step_res)
   );

   always_comb begin
      item_in.mode           = req_mode;
      item_in.dir_in         = req_dir_in;
      item_in.data_length    = req_data_length;
      item_in.device_present = req_device_present;
      item_in.pipe_idle      = req_pipe_idle;
      item_in.urb_state      = urb_type'(req_urb_state);

      // input register empties when its transaction steps, refills on a take
      in_valid_in = req_take || (in_valid_ff && !step_fire);

      // context only moves when a transaction actually steps
      ctx_in = step_fire ? step_ctx : ctx_ff;

      res_in       = step_fire ? step_res : res_ff;
      out_valid_in = step_fire || (out_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         ctx_ff.stage         <= STAGE_IDLE;
         ctx_ff.retry_used    <= 1'b0;
         ctx_ff.direction_in  <= 1'b0;
         ctx_ff.stored_length <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctx_ff       <= ctx_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = res_ff.action;
   assign rsp_success         = res_ff.success;
   assign rsp_transfer_length = res_ff.transfer_length;

endmodule

`default_nettype wire

// File: src/ucts_checker.sv
// Port-level checker for the USB control transfer sequencer, bound to the top level.
// Depends on ucts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ucts_checker
   import ucts_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             req_mode,
   input wire logic             req_dir_in,
   input wire logic [LEN_W-1:0] req_data_length,
   input wire logic             req_device_present,
   input wire logic             req_pipe_idle,
   input wire logic [1:0]       req_urb_state,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [2:0]       rsp_action,
   input wire logic             rsp_success,
   input wire logic [LEN_W-1:0] rsp_transfer_length
);

   logic             rsp_wait;
   logic             rsp_fin;
   logic             rsp_data;
   logic [LEN_W+3:0] rsp_payload;

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_fin     = (rsp_action == ACT_FINISHED);
   assign rsp_data    = (rsp_action == ACT_DATA_IN) || (rsp_action == ACT_DATA_OUT);
   assign rsp_payload = {rsp_action, rsp_success, rsp_transfer_length};

   // response register is empty after reset
   `ASSERT_ALL(a_rst_empty, clock, reset |=> !rsp_valid)

   // request side only backs up behind a pending response
   `ASSERT_ALL(a_stall_cause, clock, !rsp_valid |-> !req_stall)

   // success only comes with a finished verdict
   `ASSERT_RST(a_success_fin, clock, reset, (rsp_valid && rsp_success) |-> rsp_fin)

   // length only reported for data stages
   `ASSERT_RST(a_len_data, clock, reset, (rsp_valid && !rsp_data) |-> (rsp_transfer_length == '0))

   // stalled response holds
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_wait |=> (rsp_valid && $stable(rsp_payload)))

endmodule

bind usb_control_transfer_sequencer ucts_checker u_ucts_checker (.*);

`default_nettype wire
